// ===== rtl/core/sced_pkg.sv =====
// shared widths, constants, types and the exp factor function for the coherence pipeline
package sced_pkg;

  localparam int COORD_W  = 32;
  localparam int COEF_W   = 16;
  localparam int FREQ_W   = 32;
  localparam int SPEED_W  = 31;
  localparam int COH_W    = 17;
  localparam int CFG_IDX_W = 2;

  localparam int DIFF_W   = COORD_W + 1;
  localparam int AW       = 48;
  localparam int AH_W     = AW / 2;
  localparam int SQ1_W    = 2 * AW;
  localparam int SQ_W     = SQ1_W + 2;
  localparam int DIST_W   = 51;
  localparam int F16_W    = FREQ_W + 11;
  localparam int SSUM_W   = SPEED_W + 1;
  localparam int M_W      = SSUM_W + 9;
  localparam int NUM_W    = F16_W + DIST_W;
  localparam int X_W      = 32;
  localparam int ACC_W    = 63;
  localparam int EF_W     = 62;
  localparam int PROD_W   = ACC_W + EF_W + 1;
  localparam int LATENCY  = 155;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_Z = 2'd2;

  localparam logic [COEF_W-1:0] DECAY_X_RST = 16'd2560;
  localparam logic [COEF_W-1:0] DECAY_Y_RST = 16'd1792;
  localparam logic [COEF_W-1:0] DECAY_Z_RST = 16'd1536;

  localparam logic [8:0]       PI_X100  = 9'd314;
  localparam logic [ACC_W-1:0] ONE_Q62  = {1'b1, 62'd0};
  localparam logic [EF_W-1:0]  EXP_BIT0 = 62'h3FFF_FFFC_0000_0020;

  typedef struct packed {
    logic              zero;
    logic [F16_W-1:0]  f1600;
    logic [SSUM_W-1:0] ssum;
  } sced_side_t;

  typedef struct packed {
    logic zero;
    logic big;
  } sced_flags_t;

  // exp(-2^(b-28)) in q0.62, by repeated rounded squaring
  function automatic logic [EF_W-1:0] exp_factor(input int b);
    logic [127:0]    p;
    logic [EF_W-1:0] e;
    e = EXP_BIT0;
    for (int i = 0; i < b; i++) begin
      p = {66'd0, e} * {66'd0, e};
      p = p + (128'd1 << 61);
      e = p[123:62];
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/spatial_coherence_exp_decay_top.sv =====
// top level: weighted distance, square root, division and exp pipeline for coherence
// path of a transaction: stages 1-4, root, stages 5-7, divider, exp chain, output register
// throughput: one transaction per cycle, set by the fully pipelined root, divider and exp chain
// busy never rises; the result is shown for a single cycle and cannot be held off
// synchronous active-low reset clears all valid bits and loads the decay coefficient defaults
module spatial_coherence_exp_decay_top
  import sced_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  in_j_x,
  input  logic signed [COORD_W-1:0]  in_j_y,
  input  logic signed [COORD_W-1:0]  in_j_z,
  input  logic signed [COORD_W-1:0]  in_k_x,
  input  logic signed [COORD_W-1:0]  in_k_y,
  input  logic signed [COORD_W-1:0]  in_k_z,
  input  logic [FREQ_W-1:0]          in_freq,
  input  logic [SPEED_W-1:0]         in_speed_j,
  input  logic [SPEED_W-1:0]         in_speed_k,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_addr,
  input  logic [COEF_W-1:0]          cfg_wdata,
  output logic                       out_valid,
  output logic [COH_W-1:0]           out_coherence,
  output logic                       out_speed_sum_zero
);

  localparam int DW = 32;

  function automatic logic [AW-1:0] weigh(input logic [COEF_W-1:0] c,
                                          input logic [COORD_W-1:0] p,
                                          input logic [COORD_W-1:0] q);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    logic [COEF_W+DIFF_W-1:0] prod;
    d    = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    m    = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    prod = {{DIFF_W{1'b0}}, c} * {{COEF_W{1'b0}}, m};
    return prod[AW-1:0];
  endfunction

  logic [COEF_W-1:0] decay_x_r, decay_y_r, decay_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_x_r <= DECAY_X_RST;
      decay_y_r <= DECAY_Y_RST;
      decay_z_r <= DECAY_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DECAY_X: decay_x_r <= cfg_wdata;
        REG_DECAY_Y: decay_y_r <= cfg_wdata;
        REG_DECAY_Z: decay_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: weighted axis distances, speed sum, scaled frequency
  logic              v1_r;
  logic [AW-1:0]     a1_r [3];
  sced_side_t        side1_r;
  sced_side_t        side1_nxt;
  logic [SSUM_W-1:0] ssum;
  logic [F16_W-1:0]  fext;

  assign ssum = {1'b0, in_speed_j} + {1'b0, in_speed_k};
  assign fext = {11'd0, in_freq};

  always_comb begin
    side1_nxt.ssum  = ssum;
    side1_nxt.zero  = (ssum == '0);
    side1_nxt.f1600 = (fext << 10) + (fext << 9) + (fext << 6);
  end

  always_ff @(posedge clk) begin
    a1_r[0] <= weigh(decay_x_r, in_j_x, in_k_x);
    a1_r[1] <= weigh(decay_y_r, in_j_y, in_k_y);
    a1_r[2] <= weigh(decay_z_r, in_j_z, in_k_z);
    side1_r <= side1_nxt;
  end

  // stage 2: square partial products
  logic            v2_r;
  logic [AW-1:0]   hh2_r [3];
  logic [AW-1:0]   hl2_r [3];
  logic [AW-1:0]   ll2_r [3];
  sced_side_t      side2_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh2_r[i] <= AW'(a1_r[i][AW-1:AH_W]) * AW'(a1_r[i][AW-1:AH_W]);
      hl2_r[i] <= AW'(a1_r[i][AW-1:AH_W]) * AW'(a1_r[i][AH_W-1:0]);
      ll2_r[i] <= AW'(a1_r[i][AH_W-1:0]) * AW'(a1_r[i][AH_W-1:0]);
    end
    side2_r <= side1_r;
  end

  // stage 3: per-axis squares
  logic             v3_r;
  logic [SQ1_W-1:0] sq3_r [3];
  sced_side_t       side3_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq3_r[i] <= (SQ1_W'(hh2_r[i]) << AW) + (SQ1_W'(hl2_r[i]) << (AH_W + 1))
                + SQ1_W'(ll2_r[i]);
    end
    side3_r <= side2_r;
  end

  // stage 4: sum of squares
  logic            v4_r;
  logic [SQ_W-1:0] rad4_r;
  sced_side_t      side4_r;

  always_ff @(posedge clk) begin
    rad4_r  <= SQ_W'(sq3_r[0]) + SQ_W'(sq3_r[1]) + SQ_W'(sq3_r[2]);
    side4_r <= side3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  logic              sq_valid;
  logic [DIST_W-1:0] sq_root;
  sced_side_t        sq_side;

  sced_sqrt_pipe u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v4_r),
    .in_radicand (rad4_r),
    .in_side     (side4_r),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_side    (sq_side)
  );

  // stage 5: numerator partial products and divisor
  logic        v5_r;
  logic [46:0] nhh5_r;
  logic [45:0] nhl5_r;
  logic [47:0] nlh5_r;
  logic [46:0] nll5_r;
  logic [M_W-1:0] m5_r;
  logic        z5_r;

  always_ff @(posedge clk) begin
    nhh5_r <= 47'(sq_side.f1600[F16_W-1:22]) * 47'(sq_root[DIST_W-1:25]);
    nhl5_r <= 46'(sq_side.f1600[F16_W-1:22]) * 46'(sq_root[24:0]);
    nlh5_r <= 48'(sq_side.f1600[21:0]) * 48'(sq_root[DIST_W-1:25]);
    nll5_r <= 47'(sq_side.f1600[21:0]) * 47'(sq_root[24:0]);
    m5_r   <= M_W'(sq_side.ssum) * M_W'(PI_X100);
    z5_r   <= sq_side.zero;
  end

  // stage 6: numerator
  logic             v6_r;
  logic [NUM_W-1:0] num6_r;
  logic [M_W-1:0]   m6_r;
  logic             z6_r;

  always_ff @(posedge clk) begin
    num6_r <= (NUM_W'(nhh5_r) << 47) + (NUM_W'(nhl5_r) << 22)
            + (NUM_W'(nlh5_r) << 25) + NUM_W'(nll5_r);
    m6_r   <= m5_r;
    z6_r   <= z5_r;
  end

  // stage 7: range check and divider set-up
  logic           v7_r;
  logic [M_W-1:0] rem7_r;
  logic [DW-1:0]  low7_r;
  logic [M_W-1:0] m7_r;
  sced_flags_t    flg7_r;

  always_ff @(posedge clk) begin
    rem7_r      <= num6_r[DW+M_W-1:DW];
    low7_r      <= num6_r[DW-1:0];
    m7_r        <= m6_r;
    flg7_r.zero <= z6_r;
    flg7_r.big  <= num6_r[NUM_W-1:DW] >= (NUM_W-DW)'(m6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v5_r <= sq_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // restoring divider, one quotient bit per stage
  logic           dv_v   [DW];
  logic [M_W-1:0] dv_rem [DW];
  logic [DW-1:0]  dv_low [DW];
  logic [X_W-1:0] dv_q   [DW];
  logic [M_W-1:0] dv_m   [DW];
  sced_flags_t    dv_flg [DW];

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic           pv;
    logic [M_W-1:0] prem;
    logic [DW-1:0]  plow;
    logic [X_W-1:0] pq;
    logic [M_W-1:0] pm;
    sced_flags_t    pflg;
    logic [M_W:0]   t;

    if (k == 0) begin : g_first
      assign pv   = v7_r;
      assign prem = rem7_r;
      assign plow = low7_r;
      assign pq   = '0;
      assign pm   = m7_r;
      assign pflg = flg7_r;
    end else begin : g_next
      assign pv   = dv_v[k-1];
      assign prem = dv_rem[k-1];
      assign plow = dv_low[k-1];
      assign pq   = dv_q[k-1];
      assign pm   = dv_m[k-1];
      assign pflg = dv_flg[k-1];
    end

    assign t = {prem, plow[DW-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[k] <= 1'b0;
      end else begin
        dv_v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      dv_low[k] <= plow << 1;
      dv_m[k]   <= pm;
      dv_flg[k] <= pflg;
      if (t >= {1'b0, pm}) begin
        dv_rem[k] <= M_W'(t - {1'b0, pm});
        dv_q[k]   <= {pq[X_W-2:0], 1'b1};
      end else begin
        dv_rem[k] <= t[M_W-1:0];
        dv_q[k]   <= {pq[X_W-2:0], 1'b0};
      end
    end
  end

  logic             ex_valid;
  logic [ACC_W-1:0] ex_acc;
  sced_flags_t      ex_flags;

  sced_exp_pipe u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_v[DW-1]),
    .in_x      (dv_q[DW-1]),
    .in_flags  (dv_flg[DW-1]),
    .out_valid (ex_valid),
    .out_acc   (ex_acc),
    .out_flags (ex_flags)
  );

  // output register
  logic             out_valid_r;
  logic [COH_W-1:0] coh_r;
  logic             ssz_r;
  logic [63:0]      rnd;

  assign rnd = {1'b0, ex_acc} + (64'd1 << 45);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    ssz_r <= ex_flags.zero;
    if (ex_flags.zero || ex_flags.big) begin
      coh_r <= '0;
    end else begin
      coh_r <= rnd[62:46];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coherence      = coh_r;
  assign out_speed_sum_zero = ssz_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe missing after transaction");

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_speed_sum_zero) |-> (out_coherence == '0))
    else $error("coherence not cleared on zero speed sum");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coherence <= COH_W'(ONE_Q62 >> 46)))
    else $error("coherence above one");

endmodule

// ===== rtl/core/sced_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
module sced_sqrt_pipe
  import sced_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_radicand,
  input  sced_side_t        in_side,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_root,
  output sced_side_t        out_side
);

  localparam int VW    = 2 * DIST_W;
  localparam int REM_W = DIST_W + 2;

  logic              vld_r  [DIST_W];
  logic [VW-1:0]     val_r  [DIST_W];
  logic [REM_W-1:0]  rem_r  [DIST_W];
  logic [DIST_W-1:0] root_r [DIST_W];
  sced_side_t        side_r [DIST_W];

  for (genvar k = 0; k < DIST_W; k++) begin : g_stage
    logic              pv;
    logic [VW-1:0]     pval;
    logic [REM_W-1:0]  prem;
    logic [DIST_W-1:0] proot;
    sced_side_t        pside;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign pval  = {{(VW-SQ_W){1'b0}}, in_radicand};
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld_r[k-1];
      assign pval  = val_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pside = side_r[k-1];
    end

    assign cur   = {prem, pval[VW-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      val_r[k]  <= pval << 2;
      side_r[k] <= pside;
      if (cur >= trial) begin
        rem_r[k]  <= REM_W'(cur - trial);
        root_r[k] <= {proot[DIST_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= REM_W'(cur);
        root_r[k] <= {proot[DIST_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld_r[DIST_W-1];
  assign out_root  = root_r[DIST_W-1];
  assign out_side  = side_r[DIST_W-1];

endmodule

// ===== rtl/core/sced_exp_pipe.sv =====
// pipelined exp(-x) in q1.62, a conditional product per exponent bit over two stages
module sced_exp_pipe
  import sced_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [X_W-1:0]   in_x,
  input  sced_flags_t      in_flags,
  output logic             out_valid,
  output logic [ACC_W-1:0] out_acc,
  output sced_flags_t      out_flags
);

  logic             vld_a [X_W];
  logic [X_W-1:0]   x_a   [X_W];
  logic [ACC_W-1:0] acc_a [X_W];
  sced_flags_t      flg_a [X_W];
  logic [63:0]      pll_a [X_W];
  logic [61:0]      plh_a [X_W];
  logic [62:0]      phl_a [X_W];
  logic [60:0]      phh_a [X_W];

  logic             vld_b [X_W];
  logic [X_W-1:0]   x_b   [X_W];
  logic [ACC_W-1:0] acc_b [X_W];
  sced_flags_t      flg_b [X_W];

  for (genvar k = 0; k < X_W; k++) begin : g_bit
    localparam logic [EF_W-1:0] EK = exp_factor(k);

    logic             pv;
    logic [X_W-1:0]   px;
    logic [ACC_W-1:0] pacc;
    sced_flags_t      pflg;
    logic [PROD_W-1:0] sum;

    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign px   = in_x;
      assign pacc = ONE_Q62;
      assign pflg = in_flags;
    end else begin : g_next
      assign pv   = vld_b[k-1];
      assign px   = x_b[k-1];
      assign pacc = acc_b[k-1];
      assign pflg = flg_b[k-1];
    end

    assign sum = PROD_W'(pll_a[k])
               + (PROD_W'(plh_a[k]) << 32)
               + (PROD_W'(phl_a[k]) << 32)
               + (PROD_W'(phh_a[k]) << 64)
               + (PROD_W'(1) << 61);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_a[k] <= 1'b0;
        vld_b[k] <= 1'b0;
      end else begin
        vld_a[k] <= pv;
        vld_b[k] <= vld_a[k];
      end
    end

    // partial products
    always_ff @(posedge clk) begin
      x_a[k]   <= px;
      acc_a[k] <= pacc;
      flg_a[k] <= pflg;
      pll_a[k] <= 64'(pacc[31:0]) * 64'(EK[31:0]);
      plh_a[k] <= 62'(pacc[31:0]) * 62'(EK[61:32]);
      phl_a[k] <= 63'(pacc[62:32]) * 63'(EK[31:0]);
      phh_a[k] <= 61'(pacc[62:32]) * 61'(EK[61:32]);
    end

    // sum, round half up, keep when bit clear
    always_ff @(posedge clk) begin
      x_b[k]   <= x_a[k];
      flg_b[k] <= flg_a[k];
      if (x_a[k][k]) begin
        acc_b[k] <= sum[PROD_W-2:EF_W];
      end else begin
        acc_b[k] <= acc_a[k];
      end
    end
  end

  assign out_valid = vld_b[X_W-1];
  assign out_acc   = acc_b[X_W-1];
  assign out_flags = flg_b[X_W-1];

endmodule

// ===== test/spatial_coherence_exp_decay_checker.sv =====
// checker: watches the coherence block's channels, predicts each result and compares it
module spatial_coherence_exp_decay_checker
  import sced_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [COORD_W-1:0] in_j_x,
  input  logic signed [COORD_W-1:0] in_j_y,
  input  logic signed [COORD_W-1:0] in_j_z,
  input  logic signed [COORD_W-1:0] in_k_x,
  input  logic signed [COORD_W-1:0] in_k_y,
  input  logic signed [COORD_W-1:0] in_k_z,
  input  logic [FREQ_W-1:0]         in_freq,
  input  logic [SPEED_W-1:0]        in_speed_j,
  input  logic [SPEED_W-1:0]        in_speed_k,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_addr,
  input  logic [COEF_W-1:0]         cfg_wdata,
  input  logic                      out_valid,
  input  logic [COH_W-1:0]          out_coherence,
  input  logic                      out_speed_sum_zero,
  output int                        mismatches,
  output int                        pending
);

  typedef struct packed {
    logic [COH_W-1:0] coh;
    logic             zero;
  } coh_result_t;

  logic [COEF_W-1:0] coef_x, coef_y, coef_z;
  coh_result_t       expected_q[$];

  // weighted absolute difference, exact
  function automatic logic [47:0] weigh(input logic [COEF_W-1:0] coef,
                                        input logic signed [COORD_W-1:0] p,
                                        input logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        mag;
    d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    mag = d[COORD_W] ? -d : d;
    return 48'(coef) * 48'(mag);
  endfunction

  // q2.62 product rounded half up
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << 61);
    return 64'(p >> 62);
  endfunction

  function automatic coh_result_t predict_coherence(input logic [47:0] ax, ay, az,
                                                    input logic [FREQ_W-1:0] f,
                                                    input logic [SPEED_W-1:0] sj, sk);
    coh_result_t  r;
    logic [31:0]  s;
    logic [127:0] sq, num, lim;
    logic [50:0]  droot, c;
    logic [31:0]  xq, cx;
    logic [40:0]  m;
    logic [63:0]  acc, ef;
    s = 32'(sj) + 32'(sk);
    r.zero = 1'b0;
    r.coh = '0;
    if (s == 0) begin
      r.zero = 1'b1;
      return r;
    end
    sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
    droot = '0;
    for (int b = 50; b >= 0; b--) begin
      c = droot | (51'd1 << b);
      if (128'(c) * 128'(c) <= sq) droot = c;
    end
    num = 128'(64'(f) * 64'd1600) * 128'(droot);
    m = 41'(s) * 41'd314;
    lim = 128'(m) << 32;
    if (lim <= num) return r;
    xq = '0;
    for (int b = 31; b >= 0; b--) begin
      cx = xq | (32'd1 << b);
      if (128'(m) * 128'(cx) <= num) xq = cx;
    end
    acc = 64'(ONE_Q62);
    ef = 64'(EXP_BIT0);
    for (int b = 0; b < 32; b++) begin
      if (xq[b]) acc = mul_q62(acc, ef);
      ef = mul_q62(ef, ef);
    end
    r.coh = COH_W'((acc + (64'd1 << 45)) >> 46);
    return r;
  endfunction

  always @(posedge clk) begin
    coh_result_t exp_r;
    if (!rst_n) begin
      coef_x <= DECAY_X_RST;
      coef_y <= DECAY_Y_RST;
      coef_z <= DECAY_Z_RST;
      expected_q.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DECAY_X: coef_x <= cfg_wdata;
          REG_DECAY_Y: coef_y <= cfg_wdata;
          REG_DECAY_Z: coef_z <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_q.push_back(predict_coherence(weigh(coef_x, in_j_x, in_k_x),
                                               weigh(coef_y, in_j_y, in_k_y),
                                               weigh(coef_z, in_j_z, in_k_z),
                                               in_freq, in_speed_j, in_speed_k));
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected transaction: coherence %0d zero %0d",
                     out_coherence, out_speed_sum_zero);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.coh !== out_coherence || exp_r.zero !== out_speed_sum_zero) begin
            if (mismatches < 10)
              $display("mismatch: coherence exp %0d got %0d, zero exp %0d got %0d",
                       exp_r.coh, out_coherence, exp_r.zero, out_speed_sum_zero);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ===== test/spatial_coherence_exp_decay_top_tb.sv =====
// testbench top: clock, reset, stimulus and verdict for the coherence block
module spatial_coherence_exp_decay_top_tb;
  import sced_pkg::*;

  localparam int WATCHDOG = 4000;

  typedef struct {
    logic signed [COORD_W-1:0] jx, jy, jz, kx, ky, kz;
    logic [FREQ_W-1:0]         f;
    logic [SPEED_W-1:0]        sj, sk;
  } pair_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_j_x = '0, in_j_y = '0, in_j_z = '0;
  logic signed [COORD_W-1:0] in_k_x = '0, in_k_y = '0, in_k_z = '0;
  logic [FREQ_W-1:0]         in_freq = '0;
  logic [SPEED_W-1:0]        in_speed_j = '0, in_speed_k = '0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_addr = REG_DECAY_X;
  logic [COEF_W-1:0]         cfg_wdata = '0;
  logic                      out_valid;
  logic [COH_W-1:0]          out_coherence;
  logic                      out_speed_sum_zero;
  int                        mismatches, pending;
  int                        idle_cycles = 0;
  int                        burst_left = 0;

  always #1 clk = ~clk;

  spatial_coherence_exp_decay_top i_dut (.*);

  spatial_coherence_exp_decay_checker i_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one transaction, with bursts and random gaps
  task automatic send_pair(input pair_t p);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 7));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    in_j_x <= p.jx; in_j_y <= p.jy; in_j_z <= p.jz;
    in_k_x <= p.kx; in_k_y <= p.ky; in_k_z <= p.kz;
    in_freq <= p.f; in_speed_j <= p.sj; in_speed_k <= p.sk;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    pause(1);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_decay(input logic [COEF_W-1:0] x, y, z);
    drain();
    cfg_we <= 1'b1; cfg_addr <= REG_DECAY_X; cfg_wdata <= x;
    @(posedge clk);
    cfg_addr <= REG_DECAY_Y; cfg_wdata <= y;
    @(posedge clk);
    cfg_addr <= REG_DECAY_Z; cfg_wdata <= z;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] scaled(input int max_shift);
    return $urandom >> $urandom_range(0, max_shift);
  endfunction

  function automatic pair_t mk(input logic [31:0] jx, jy, jz, kx, ky, kz, f,
                               input logic [30:0] sj, sk);
    pair_t p;
    p.jx = jx; p.jy = jy; p.jz = jz; p.kx = kx; p.ky = ky; p.kz = kz;
    p.f = f; p.sj = sj; p.sk = sk;
    return p;
  endfunction

  function automatic pair_t rand_pair;
    pair_t p;
    int    mode;
    mode = $urandom_range(0, 9);
    p = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           31'($urandom), 31'($urandom));
    if (mode >= 2) begin
      // close points with low frequency so the exponent stays in range
      p.kx = p.jx - (($urandom_range(0, 1) ? -1 : 1) * int'(scaled(31) >> 8));
      p.ky = p.jy - (($urandom_range(0, 1) ? -1 : 1) * int'(scaled(31) >> 8));
      p.kz = p.jz - (($urandom_range(0, 1) ? -1 : 1) * int'(scaled(31) >> 8));
      p.f = scaled(31) >> 6;
      p.sj = 31'(scaled(30));
      p.sk = 31'(scaled(30));
    end
    if (mode == 1) begin
      p.sj = '0;
      if ($urandom_range(0, 1)) p.sk = '0;
    end
    if (mode == 2) p.f = '0;
    if (mode == 3) begin
      p.kx = p.jx; p.ky = p.jy; p.kz = p.jz;
    end
    return p;
  endfunction

  task automatic random_phase(input int n);
    repeat (n) send_pair(rand_pair());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and special cases at reset coefficients
    send_pair(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(mk(1, 2, 3, 4, 5, 6, 32'h0001_0000, 31'd0, 31'd0));
    send_pair(mk(0, 0, 0, 0, 0, 0, 32'h0000_0000, 31'd0, 31'd0));
    send_pair(mk(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0, 31'h0001_0000, 31'h0001_0000));
    send_pair(mk(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hFFFF_FFFF,
                 31'd1, 31'd0));
    send_pair(mk(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 31'h000A_0000, 31'h000A_0000));
    send_pair(mk(0, 32'h0000_8000, 0, 0, 0, 32'h0000_4000, 32'h0000_2000,
                 31'h0005_0000, 31'h0003_0000));
    send_pair(mk(0, 0, 0, 32'd1, 32'd1, 32'd1, 32'd1, 31'd0, 31'd1));
    send_pair(mk(32'hFFFF_FFFF, 0, 0, 32'd0, 0, 0, 32'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_pair(mk(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 0, 0, 0, 32'h0064_0000,
                 31'd1, 31'd1));
    send_pair(mk(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd0));
    random_phase(150);

    set_decay('0, '0, '0);
    send_pair(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 31'd1, 31'd0));
    random_phase(100);

    set_decay(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 31'd1, 31'd0));
    send_pair(mk(32'd1, 0, 0, 0, 0, 0, 32'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    random_phase(100);

    set_decay(16'h0001, 16'hFFFF, 16'h0000);
    random_phase(100);

    set_decay(16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(100);

    set_decay(DECAY_X_RST, DECAY_Y_RST, DECAY_Z_RST);
    random_phase(90);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
